// File: hw/rtl/f2m_pkg.sv
// Shared types, constants and the pitch boundary table of the frequency to MIDI block.
// Used by f2m_note_index, f2m_contour and frequency_to_midi_contour. No dependencies.
`timescale 1ns / 1ps

package f2m_pkg;

	// Table size and field widths.
	localparam int NOTE_COUNT       = 87;
	localparam int NOTE_IDX_W       = $clog2(NOTE_COUNT);
	localparam int FREQ_W           = 20;
	localparam int NOTE_W           = 8;
	localparam int OFFSET_W         = 7;
	localparam int CONTOUR_W        = 2;
	localparam int BOUND_W          = 24;
	localparam int SEMITONES        = 12;
	localparam int OCTAVE_SHIFT_MAX = 10;

	// Stream payload widths, padded to whole bytes.
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	localparam logic [OFFSET_W-1:0] NOTE_OFFSET_RESET = OFFSET_W'(21);

	typedef logic [BOUND_W-1:0] bound_t;

	// Midpoints between neighboring pitches of the lowest octave, Hz*256 scaled by 1024.
	localparam bound_t MID_BASE [SEMITONES] = '{
		24'd7423293,  24'd7864705,  24'd8332365,  24'd8827833,
		24'd9352763,  24'd9908908,  24'd10498122, 24'd11122373,
		24'd11783743, 24'd12484441, 24'd13226805, 24'd14013312
	};

	// Parsons contour codes.
	typedef enum logic [CONTOUR_W-1:0] {
		CONTOUR_NONE = 2'd0,
		CONTOUR_UP   = 2'd1,
		CONTOUR_DOWN = 2'd2,
		CONTOUR_SAME = 2'd3
	} contour_t;

	// Control handed from the pipeline to the contour tracker.
	typedef struct packed {
		logic advance;
		logic first_note;
	} f2m_ctrl_t;

	// Boundary between pitch idx and idx+1 in Hz*256. Octaves above the
	// shift range get an all-ones boundary, which a frequency never exceeds.
	function automatic bound_t note_boundary(input int idx);
		int     octave;
		bound_t result;
		octave = idx / SEMITONES;
		if (octave > OCTAVE_SHIFT_MAX) begin
			result = '1;
		end else begin
			result = MID_BASE[idx % SEMITONES] >> (OCTAVE_SHIFT_MAX - octave);
		end
		return result;
	endfunction

endpackage

// File: hw/rtl/f2m_note_index.sv
// Comparator bank that maps a frequency to the nearest equal-tempered table index.
// Depends on f2m_pkg for the boundary table and widths.
`timescale 1ns / 1ps

module f2m_note_index
	import f2m_pkg::*;
(
	input  logic [FREQ_W-1:0]     frequency,
	output logic [NOTE_IDX_W-1:0] note_index
);

	logic [NOTE_COUNT-2:0] above;

	// Compare against every midpoint in parallel; on a tie the lower note wins.
	always_comb begin
		for (int i = 0; i < NOTE_COUNT - 1; i++) begin
			above[i] = BOUND_W'(frequency) > note_boundary(i);
		end
	end

	// The boundaries rise monotonically, so the compare results form a thermometer code.
	// The highest exceeded boundary, plus one, is the index.
	always_comb begin
		note_index = '0;
		for (int i = 0; i < NOTE_COUNT - 1; i++) begin
			if (above[i]) begin
				note_index = NOTE_IDX_W'(i + 1);
			end
		end
	end

endmodule

// File: hw/rtl/f2m_contour.sv
// Parsons contour tracker: remembers the previous note of the tune and codes the step.
// Depends on f2m_pkg for the contour codes and control struct.
`timescale 1ns / 1ps

module f2m_contour
	import f2m_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  f2m_ctrl_t         ctrl,
	input  logic [NOTE_W-1:0] note,
	output contour_t          contour
);

	logic [NOTE_W-1:0] prev_note_q;
	logic              have_prev_q;

	// Code the step from the previous note; a new tune or a fresh reset has none.
	always_comb begin
		priority if (ctrl.first_note || !have_prev_q) begin
			contour = CONTOUR_NONE;
		end else if (note > prev_note_q) begin
			contour = CONTOUR_UP;
		end else if (note < prev_note_q) begin
			contour = CONTOUR_DOWN;
		end else begin
			contour = CONTOUR_SAME;
		end
	end

	// Remember the note each time a transaction moves on to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_note_q <= '0;
			have_prev_q <= 1'b0;
		end else if (ctrl.advance) begin
			prev_note_q <= note;
			have_prev_q <= 1'b1;
		end
	end

	a_have_prev_set: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.advance |=> have_prev_q)
		else $error("previous note flag not set after a note moved on");

	a_prev_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.advance |=> prev_note_q == $past(note))
		else $error("previous note does not match the last note passed on");

	a_prev_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.advance |=> $stable(prev_note_q) && $stable(have_prev_q))
		else $error("contour state changed without a note moving on");

endmodule

// File: hw/rtl/frequency_to_midi_contour.sv
// Top level of the frequency to MIDI note and Parsons contour block.
// Depends on f2m_pkg, f2m_note_index and f2m_contour.
`timescale 1ns / 1ps

// The block takes one transaction per clock cycle while the output side is not
// stalled and returns one result per input, in order, from the result register. The
// input register feeds a bank of parallel comparators against the constant pitch
// midpoints, whose count plus note_offset is the MIDI note; the contour against the
// previous note is formed in the same cycle and both land in the result register.
// A new transaction can be accepted every cycle unless the output stalls; the
// comparator-and-add path only sets the clock rate. While a result waits on the
// output side, the input register still takes one more transaction, so the block holds
// at most two. Write note_offset (reset 21) only while no transaction is in flight.

module frequency_to_midi_contour
	import f2m_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration: note_offset.
	input  logic                 cfg_we,
	input  logic [OFFSET_W-1:0]  cfg_wdata,
	// Input stream.
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [19:0] frequency, rest zero
	input  logic                 s_axis_tuser,  // [0] first_note
	// Result stream.
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata   // [7:0] midi_note, [9:8] contour
);

	logic [OFFSET_W-1:0]   note_offset_q;
	logic                  valid_s1;
	logic [FREQ_W-1:0]     freq_s1;
	logic                  first_s1;
	logic                  valid_s2;
	logic [NOTE_W-1:0]     note_s2;
	contour_t              contour_s2;
	logic                  advance_s1;
	logic                  load_s1;
	logic [NOTE_IDX_W-1:0] note_index;
	logic [NOTE_W-1:0]     note;
	contour_t              contour;
	f2m_ctrl_t             ctrl;

	// Handshake: stage one moves on when the result register is free or draining.
	assign advance_s1    = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance_s1;
	assign load_s1       = s_axis_tvalid && s_axis_tready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_offset_q <= NOTE_OFFSET_RESET;
		end else if (cfg_we) begin
			note_offset_q <= cfg_wdata;
		end
	end

	// Valid flags of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (advance_s1) begin
				valid_s1 <= 1'b0;
			end
			if (advance_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Input payload register.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			freq_s1  <= s_axis_tdata[FREQ_W-1:0];
			first_s1 <= s_axis_tuser;
		end
	end

	f2m_note_index u_note_index (
		.frequency  (freq_s1),
		.note_index (note_index)
	);

	// MIDI note wraps modulo 256.
	assign note = NOTE_W'(note_index) + NOTE_W'(note_offset_q);

	assign ctrl.advance    = advance_s1;
	assign ctrl.first_note = first_s1;

	f2m_contour u_contour (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.note    (note),
		.contour (contour)
	);

	// Result payload register.
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			note_s2    <= note;
			contour_s2 <= contour;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {(M_TDATA_W - NOTE_W - CONTOUR_W)'(0), contour_s2, note_s2};

endmodule

// File: bench/tb_top.sv
// Self-checking bench for frequency_to_midi_contour: directed table, then random notes.
// Depends on f2m_pkg and the block's RTL; results are checked against a local pitch predictor.
`timescale 1ns / 1ps

module tb_top;
	import f2m_pkg::*;

	// Lowest-octave pitch midpoints in Hz*256, scaled by 1024.
	localparam logic [23:0] SEMI_MID [12] = '{
		24'd7423293,  24'd7864705,  24'd8332365,  24'd8827833,
		24'd9352763,  24'd9908908,  24'd10498122, 24'd11122373,
		24'd11783743, 24'd12484441, 24'd13226805, 24'd14013312
	};
	localparam int TOP_SHIFT   = 10;
	localparam int SEG_ITEMS   = 250;
	localparam int SEG_COUNT   = 6;
	localparam int DRAIN_WAIT  = 4;

	typedef struct packed {
		logic [NOTE_W-1:0] note;
		contour_t          contour;
	} midi_result_t;

	// One row of the directed table; typed rows carry a hand-written expectation.
	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic              first;
		logic              typed;
		logic [NOTE_W-1:0] note;
		contour_t          contour;
	} note_row_t;

	localparam int ROW_COUNT = 17;
	localparam note_row_t NOTE_ROWS [ROW_COUNT] = '{
		'{20'd0,       1'b0, 1'b1, 8'd21,  CONTOUR_NONE},  // first item after reset
		'{20'd7249,    1'b0, 1'b1, 8'd21,  CONTOUR_SAME},  // tie on lowest boundary
		'{20'd7250,    1'b0, 1'b1, 8'd22,  CONTOUR_UP},
		'{20'hFFFFF,   1'b0, 1'b1, 8'd107, CONTOUR_UP},    // above the table
		'{20'd983088,  1'b0, 1'b1, 8'd106, CONTOUR_DOWN},  // tie on highest boundary
		'{20'd983089,  1'b0, 1'b1, 8'd107, CONTOUR_UP},
		'{20'hFFFFF,   1'b1, 1'b1, 8'd107, CONTOUR_NONE},  // new tune
		'{20'd0,       1'b1, 1'b1, 8'd21,  CONTOUR_NONE},
		'{20'd112640,  1'b0, 1'b1, 8'd69,  CONTOUR_UP},    // 440 Hz
		'{20'd109479,  1'b0, 1'b0, 8'd0,   CONTOUR_NONE},
		'{20'd109480,  1'b0, 1'b0, 8'd0,   CONTOUR_NONE},
		'{20'd13684,   1'b0, 1'b0, 8'd0,   CONTOUR_NONE},
		'{20'd13685,   1'b1, 1'b0, 8'd0,   CONTOUR_NONE},
		'{20'hAAAAA,   1'b0, 1'b0, 8'd0,   CONTOUR_NONE},
		'{20'h55555,   1'b0, 1'b0, 8'd0,   CONTOUR_NONE},
		'{20'd1,       1'b0, 1'b0, 8'd0,   CONTOUR_NONE},
		'{20'h80000,   1'b0, 1'b0, 8'd0,   CONTOUR_NONE}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [OFFSET_W-1:0]  cfg_wdata = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // [19:0] frequency, rest zero
	logic                 s_axis_tuser = 1'b0; // [0] first_note
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;       // [7:0] midi_note, [9:8] contour

	// Predictor state and the notes still owed by the block.
	logic [OFFSET_W-1:0]  offset_model = OFFSET_W'(21);
	logic [NOTE_W-1:0]    last_note_model = '0;
	logic                 tune_open_model = 1'b0;
	midi_result_t         notes_owed [$];
	int                   mismatches = 0;
	int                   src_idle_pct = 30;
	int                   sink_stall_pct = 71;

	frequency_to_midi_contour i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Generous limit on the whole run.
	initial begin
		#6000000;
		$display("FAILURE");
		$finish;
	end

	// Boundary between pitch idx and idx+1; octaves past the shift range are never exceeded.
	function automatic logic [23:0] pitch_midpoint(input int idx);
		int octave;
		octave = idx / 12;
		if (octave > TOP_SHIFT) begin
			return '1;
		end
		return SEMI_MID[idx % 12] >> (TOP_SHIFT - octave);
	endfunction

	// Predict the note and contour of one accepted transaction and queue the expectation.
	task automatic record_note(input logic [FREQ_W-1:0] freq, input logic first,
		input logic typed, input logic [NOTE_W-1:0] typed_note, input contour_t typed_contour);
		int           pitch_idx;
		midi_result_t guess;
		pitch_idx = 0;
		for (int i = 0; i < NOTE_COUNT - 1; i++) begin
			if (24'(freq) > pitch_midpoint(i)) begin
				pitch_idx++;
			end
		end
		guess.note = NOTE_W'(pitch_idx) + NOTE_W'(offset_model);
		if (first || !tune_open_model) begin
			guess.contour = CONTOUR_NONE;
		end else if (guess.note > last_note_model) begin
			guess.contour = CONTOUR_UP;
		end else if (guess.note < last_note_model) begin
			guess.contour = CONTOUR_DOWN;
		end else begin
			guess.contour = CONTOUR_SAME;
		end
		last_note_model = guess.note;
		tune_open_model = 1'b1;
		if (typed) begin
			guess.note = typed_note;
			guess.contour = typed_contour;
		end
		notes_owed = {notes_owed, guess};
	endtask

	// Offer one note, idling first at random, and return at the edge that accepts it.
	task automatic send_note(input logic [FREQ_W-1:0] freq, input logic first,
		input logic typed, input logic [NOTE_W-1:0] typed_note, input contour_t typed_contour);
		bit taken;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= S_TDATA_W'(freq);
		s_axis_tuser <= first;
		do begin
			@(negedge clk);
			taken = s_axis_tready;
			@(posedge clk);
		end while (!taken);
		record_note(freq, first, typed, typed_note, typed_contour);
	endtask

	// Let the block drain, then write note_offset.
	task automatic write_offset(input logic [OFFSET_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (notes_owed.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		offset_model = value;
	endtask

	// Result side: random stalls, redrawn every cycle.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Signals are stable between the falling edge and the next rising edge, so a
	// transaction seen here completes at that rising edge.
	always @(negedge clk) begin
		midi_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (notes_owed.size() == 0) begin
				$display("%0t: unexpected result, actual note %0d contour %0d", $time,
					m_axis_tdata[7:0], m_axis_tdata[9:8]);
				mismatches++;
			end else begin
				want = notes_owed.pop_front();
				if (m_axis_tdata[7:0] !== want.note) begin
					$display("%0t: midi_note mismatch, expected %0d, actual %0d", $time,
						want.note, m_axis_tdata[7:0]);
					mismatches++;
				end
				if (m_axis_tdata[9:8] !== want.contour) begin
					$display("%0t: contour mismatch, expected %0d, actual %0d", $time,
						want.contour, m_axis_tdata[9:8]);
					mismatches++;
				end
			end
		end
	end

	// Main sequence.
	initial begin
		logic [FREQ_W-1:0]   freq;
		logic [FREQ_W-1:0]   prev_freq;
		logic [OFFSET_W-1:0] seg_offset;
		int                  pick;
		prev_freq = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed notes at the reset offset.
		for (int r = 0; r < ROW_COUNT; r++) begin
			send_note(NOTE_ROWS[r].freq, NOTE_ROWS[r].first, NOTE_ROWS[r].typed,
				NOTE_ROWS[r].note, NOTE_ROWS[r].contour);
		end

		// Random segments, each under its own offset; the idling pattern changes every two segments.
		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			case (seg)
				0: seg_offset = '0;
				1: seg_offset = '1;
				3: seg_offset = OFFSET_W'(1);
				4: seg_offset = OFFSET_W'(126);
				default: seg_offset = OFFSET_W'($urandom_range(127));
			endcase
			write_offset(seg_offset);
			if (seg < 2) begin
				src_idle_pct = 30;
				sink_stall_pct = 71;
			end else if (seg < 4) begin
				src_idle_pct = 71;
				sink_stall_pct = 30;
			end else begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			for (int n = 0; n < SEG_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 35) begin
					// Close to a pitch boundary, ties included.
					freq = FREQ_W'(int'(pitch_midpoint($urandom_range(NOTE_COUNT - 2)))
						+ $urandom_range(4) - 2);
				end else if (pick < 50) begin
					// Held note, to produce repeats.
					freq = prev_freq;
				end else if (pick < 75) begin
					freq = FREQ_W'($urandom());
				end else if (pick < 88) begin
					freq = FREQ_W'($urandom_range(8000));
				end else begin
					freq = FREQ_W'($urandom_range(1048575, 900000));
				end
				prev_freq = freq;
				send_note(freq, ($urandom_range(99) < 10), 1'b0, '0, CONTOUR_NONE);
			end
		end

		// Drain and finish.
		s_axis_tvalid <= 1'b0;
		while (notes_owed.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/f2m_pkg.sv
hw/rtl/f2m_note_index.sv
hw/rtl/f2m_contour.sv
hw/rtl/frequency_to_midi_contour.sv
bench/tb_top.sv
